@@ hw/rtl/ecpa_pkg.sv @@
// Shared types, constants and modular add/subtract functions for the elliptic curve point adder.
`default_nettype none
package ecpa_pkg;
	localparam int FieldBits = 31;
	localparam int CntBits = 6;
	typedef logic [FieldBits-1:0] fe_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RED_START, ST_RED_WAIT, ST_CHECK, ST_SQ_START, ST_SQ_WAIT,
		ST_NUM, ST_POW_SQ, ST_POW_SQW, ST_POW_MU, ST_POW_MUW, ST_SL_START, ST_SL_WAIT,
		ST_S2_START, ST_S2_WAIT, ST_X3, ST_Y_START, ST_Y_WAIT, ST_DONE
	} state_t;

	// Modular add of two reduced values.
	function automatic fe_t fadd(fe_t u, fe_t v, fe_t m);
		logic [FieldBits:0] s;
		s = {1'b0, u} + {1'b0, v};
		if (s >= {1'b0, m}) s = s - {1'b0, m};
		return s[FieldBits-1:0];
	endfunction

	function automatic fe_t fsub(fe_t u, fe_t v, fe_t m);
		return (u >= v) ? fe_t'(u - v) : fe_t'(u + (m - v));
	endfunction
endpackage
`default_nettype wire

@@ hw/rtl/ecpa_modmul.sv @@
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
`default_nettype none
module ecpa_modmul (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire ecpa_pkg::fe_t   u,
	input  wire ecpa_pkg::fe_t   v,
	input  wire ecpa_pkg::fe_t   m,
	output logic                 done,
	output ecpa_pkg::fe_t        prod
);
	ecpa_pkg::fe_t acc_q, u_q, v_q;
	logic [ecpa_pkg::CntBits-1:0] cnt_q;
	logic busy_q;
	ecpa_pkg::fe_t dbl, nxt;

	always_comb begin
		dbl = ecpa_pkg::fadd(acc_q, acc_q, m);
		nxt = v_q[ecpa_pkg::FieldBits-1] ? ecpa_pkg::fadd(dbl, u_q, m) : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= ecpa_pkg::CntBits'(ecpa_pkg::FieldBits - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			u_q <= u;
			v_q <= v;
		end else if (busy_q) begin
			acc_q <= nxt;
			v_q <= {v_q[ecpa_pkg::FieldBits-2:0], 1'b0};
		end
	end

	assign prod = acc_q;
endmodule
`default_nettype wire

@@ hw/rtl/ecpa_modred.sv @@
// Bit-serial reduction of a raw value modulo p, one dividend bit per cycle.
`default_nettype none
module ecpa_modred (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire ecpa_pkg::fe_t   x,
	input  wire ecpa_pkg::fe_t   m,
	output logic                 done,
	output ecpa_pkg::fe_t        rem
);
	ecpa_pkg::fe_t r_q, x_q;
	logic [ecpa_pkg::CntBits-1:0] cnt_q;
	logic busy_q;
	logic [ecpa_pkg::FieldBits:0] sh;

	assign sh = {r_q, x_q[ecpa_pkg::FieldBits-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= ecpa_pkg::CntBits'(ecpa_pkg::FieldBits - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			x_q <= x;
		end else if (busy_q) begin
			r_q <= (sh >= {1'b0, m}) ? ecpa_pkg::fe_t'(sh - {1'b0, m})
				: sh[ecpa_pkg::FieldBits-1:0];
			x_q <= {x_q[ecpa_pkg::FieldBits-2:0], 1'b0};
		end
	end

	assign rem = r_q;
endmodule
`default_nettype wire

@@ hw/rtl/elliptic_curve_point_add_core.sv @@
// Top level of the affine elliptic curve point adder over GF(p).
//
// Input stream s_axis: one word carries both points. Output stream m_axis:
// one word per input with the sum and an infinity flag in tuser.
// Registers: index 0 is curve_a, index 1 is prime_modulus (reset 1 and 11).
// Items are processed one at a time. Every product and squaring goes through one
// bit-serial modular multiplier; the five input reductions go through one
// bit-serial reducer. The inverse d^(p-2) takes one squaring for each of 31
// exponent bits plus one product for each one bit of p-2. Special results
// (vertical chord, doubling with y = 0) skip the inversion; a modulus below
// two skips the reductions and gives a zero sum.
// s_axis_tready is high only while idle. The result waits in an output
// register until taken; a stalled receiver holds the block in that state.
// Reset clears control state and loads the register reset values.
`default_nettype none
module elliptic_curve_point_add_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [30:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// first_x[30:0], first_y[61:31], second_x[92:62], second_y[123:93]
	input  wire logic [127:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// sum_x[30:0], sum_y[61:31]
	output logic [63:0]       m_axis_tdata,
	// at_infinity[0]
	output logic              m_axis_tuser
);
	localparam int FB = ecpa_pkg::FieldBits;
	typedef ecpa_pkg::fe_t fe_t;

	fe_t a_q, p_q;
	ecpa_pkg::state_t st_q, st_d;
	fe_t raw_q [5];
	fe_t x1_q, y1_q, x2_q, y2_q, ar_q, num_q, den_q, r_q, s_q, x3_q, out_x_q, out_y_q;
	logic inf_q;
	logic [2:0] ri_q;
	logic [ecpa_pkg::CntBits-1:0] bit_q;

	logic mul_start, mul_done, red_start, red_done;
	fe_t mu, mv, prod, rem, pm2;

	assign pm2 = p_q - fe_t'(2);

	ecpa_modmul u_mul (.clk, .arst_n, .start(mul_start), .u(mu), .v(mv), .m(p_q),
		.done(mul_done), .prod);
	ecpa_modred u_red (.clk, .arst_n, .start(red_start), .x(raw_q[ri_q]), .m(p_q),
		.done(red_done), .rem);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ecpa_pkg::ST_IDLE:
				if (s_axis_tvalid) st_d = ecpa_pkg::ST_RED_START;
			ecpa_pkg::ST_RED_START:
				st_d = (p_q < fe_t'(2)) ? ecpa_pkg::ST_DONE : ecpa_pkg::ST_RED_WAIT;
			ecpa_pkg::ST_RED_WAIT:
				if (red_done) st_d = (ri_q == 3'd4) ? ecpa_pkg::ST_CHECK
					: ecpa_pkg::ST_RED_START;
			ecpa_pkg::ST_CHECK:
				st_d = (x1_q == x2_q && y1_q == y2_q) ? ecpa_pkg::ST_SQ_START
					: ecpa_pkg::ST_NUM;
			ecpa_pkg::ST_SQ_START: st_d = ecpa_pkg::ST_SQ_WAIT;
			ecpa_pkg::ST_SQ_WAIT: if (mul_done) st_d = ecpa_pkg::ST_NUM;
			ecpa_pkg::ST_NUM:
				st_d = (den_q == '0) ? ecpa_pkg::ST_DONE : ecpa_pkg::ST_POW_SQ;
			ecpa_pkg::ST_POW_SQ: st_d = ecpa_pkg::ST_POW_SQW;
			ecpa_pkg::ST_POW_SQW:
				if (mul_done) st_d = pm2[bit_q[4:0]] ? ecpa_pkg::ST_POW_MU
					: (bit_q == '0 ? ecpa_pkg::ST_SL_START : ecpa_pkg::ST_POW_SQ);
			ecpa_pkg::ST_POW_MU: st_d = ecpa_pkg::ST_POW_MUW;
			ecpa_pkg::ST_POW_MUW:
				if (mul_done) st_d = (bit_q == '0) ? ecpa_pkg::ST_SL_START
					: ecpa_pkg::ST_POW_SQ;
			ecpa_pkg::ST_SL_START: st_d = ecpa_pkg::ST_SL_WAIT;
			ecpa_pkg::ST_SL_WAIT: if (mul_done) st_d = ecpa_pkg::ST_S2_START;
			ecpa_pkg::ST_S2_START: st_d = ecpa_pkg::ST_S2_WAIT;
			ecpa_pkg::ST_S2_WAIT: if (mul_done) st_d = ecpa_pkg::ST_X3;
			ecpa_pkg::ST_X3: st_d = ecpa_pkg::ST_Y_START;
			ecpa_pkg::ST_Y_START: st_d = ecpa_pkg::ST_Y_WAIT;
			ecpa_pkg::ST_Y_WAIT: if (mul_done) st_d = ecpa_pkg::ST_DONE;
			ecpa_pkg::ST_DONE: if (m_axis_tready) st_d = ecpa_pkg::ST_IDLE;
			default: st_d = ecpa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (st_q == ecpa_pkg::ST_IDLE);
		m_axis_tvalid = (st_q == ecpa_pkg::ST_DONE);
		red_start = (st_q == ecpa_pkg::ST_RED_START) && (p_q >= fe_t'(2));
		mul_start = 1'b0;
		mu = r_q;
		mv = r_q;
		unique case (st_q)
			ecpa_pkg::ST_SQ_START: begin
				mul_start = 1'b1; mu = x1_q; mv = x1_q;
			end
			ecpa_pkg::ST_POW_SQ: mul_start = 1'b1;
			ecpa_pkg::ST_POW_MU: begin
				mul_start = 1'b1; mv = den_q;
			end
			ecpa_pkg::ST_SL_START: begin
				mul_start = 1'b1; mu = num_q;
			end
			ecpa_pkg::ST_S2_START: begin
				mul_start = 1'b1; mu = s_q; mv = s_q;
			end
			ecpa_pkg::ST_Y_START: begin
				mul_start = 1'b1; mu = s_q;
				mv = ecpa_pkg::fsub(x1_q, x3_q, p_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ecpa_pkg::ST_IDLE;
			a_q <= fe_t'(1);
			p_q <= fe_t'(11);
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				if (cfg_index) p_q <= cfg_data;
				else a_q <= cfg_data;
			end
		end
	end

	fe_t sq3;
	assign sq3 = ecpa_pkg::fadd(ecpa_pkg::fadd(prod, prod, p_q), prod, p_q);

	always_ff @(posedge clk) begin
		unique case (st_q)
			ecpa_pkg::ST_IDLE: begin
				raw_q[0] <= s_axis_tdata[FB-1:0];
				raw_q[1] <= s_axis_tdata[2*FB-1:FB];
				raw_q[2] <= s_axis_tdata[3*FB-1:2*FB];
				raw_q[3] <= s_axis_tdata[4*FB-1:3*FB];
				raw_q[4] <= a_q;
				ri_q <= 3'd0;
				out_x_q <= '0;
				out_y_q <= '0;
				inf_q <= 1'b0;
			end
			ecpa_pkg::ST_RED_WAIT: if (red_done) begin
				unique case (ri_q)
					3'd0: x1_q <= rem;
					3'd1: y1_q <= rem;
					3'd2: x2_q <= rem;
					3'd3: y2_q <= rem;
					default: ar_q <= rem;
				endcase
				ri_q <= ri_q + 3'd1;
			end
			ecpa_pkg::ST_NUM: begin
				r_q <= fe_t'(1);
				bit_q <= ecpa_pkg::CntBits'(FB - 1);
				if (den_q == '0) inf_q <= 1'b1;
			end
			ecpa_pkg::ST_POW_SQW: if (mul_done) begin
				r_q <= prod;
				if (!pm2[bit_q[4:0]]) bit_q <= bit_q - 1'b1;
			end
			ecpa_pkg::ST_POW_MUW: if (mul_done) begin
				r_q <= prod;
				bit_q <= bit_q - 1'b1;
			end
			ecpa_pkg::ST_SL_WAIT: if (mul_done) s_q <= prod;
			ecpa_pkg::ST_S2_WAIT: if (mul_done) x3_q <= prod;
			ecpa_pkg::ST_X3: x3_q <= ecpa_pkg::fsub(ecpa_pkg::fsub(x3_q, x1_q, p_q), x2_q, p_q);
			ecpa_pkg::ST_Y_WAIT: if (mul_done) begin
				out_x_q <= x3_q;
				out_y_q <= ecpa_pkg::fsub(prod, y1_q, p_q);
			end
			default: ;
		endcase
		// Numerator and denominator settle in the cycle before ST_NUM.
		if (st_q == ecpa_pkg::ST_CHECK && !(x1_q == x2_q && y1_q == y2_q)) begin
			num_q <= ecpa_pkg::fsub(y2_q, y1_q, p_q);
			den_q <= ecpa_pkg::fsub(x2_q, x1_q, p_q);
		end else if (st_q == ecpa_pkg::ST_SQ_WAIT && mul_done) begin
			num_q <= ecpa_pkg::fadd(sq3, ar_q, p_q);
			den_q <= ecpa_pkg::fadd(y1_q, y1_q, p_q);
		end
	end

	assign m_axis_tdata = {2'b00, out_y_q, out_x_q};
	assign m_axis_tuser = inf_q;
endmodule
`default_nettype wire

@@ tb/elliptic_curve_point_add_core_tb.sv @@
// Self-checking testbench for the elliptic curve point adder: random and directed point pairs.
module elliptic_curve_point_add_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic {
		REG_CURVE_A = 1'b0,
		REG_PRIME   = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic        inf;
		logic [30:0] y;
		logic [30:0] x;
	} sum_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic         cfg_index = 1'b0;
	logic [30:0]  cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;
	logic         m_axis_tuser;

	logic [63:0] mod_a = 1;
	logic [63:0] mod_p = 11;
	sum_t        sums_due[$];
	int          errors = 0;
	int          send_idle = 0;
	int          recv_idle = 0;

	elliptic_curve_point_add_core dut (.*);

	initial forever #6 clk = ~clk;

	// Generous bound: about 1500 words, with stalls.
	initial begin
		#(12 * 20000000);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [63:0] mulmod(logic [63:0] u, logic [63:0] v, logic [63:0] m);
		logic [127:0] prod;
		prod = u * v;
		prod = prod % m;
		return prod[63:0];
	endfunction

	function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
		logic [63:0] r;
		r = 1 % m;
		for (int i = 63; i >= 0; i--) begin
			r = mulmod(r, r, m);
			if (e[i]) r = mulmod(r, b, m);
		end
		return r;
	endfunction

	function automatic sum_t point_sum(logic [30:0] x1i, logic [30:0] y1i,
			logic [30:0] x2i, logic [30:0] y2i);
		sum_t r;
		logic [63:0] p, x1, y1, x2, y2, num, den, s, x3, y3;
		r = '0;
		p = mod_p;
		if (p < 2) return r;
		x1 = x1i % p;
		y1 = y1i % p;
		x2 = x2i % p;
		y2 = y2i % p;
		if (x1 == x2 && y1 == y2) begin
			num = (3 * mulmod(x1, x1, p) + mod_a % p) % p;
			den = (2 * y1) % p;
		end else begin
			num = (y2 + p - y1) % p;
			den = (x2 + p - x1) % p;
		end
		if (den == 0) begin
			r.inf = 1'b1;
			return r;
		end
		s = mulmod(num, powmod(den, p - 2, p), p);
		x3 = (mulmod(s, s, p) + 2 * p - x1 - x2) % p;
		y3 = (mulmod(s, (x1 + p - x3) % p, p) + p - y1) % p;
		r.x = x3[30:0];
		r.y = y3[30:0];
		return r;
	endfunction

	task automatic send_points(logic [30:0] x1, logic [30:0] y1, logic [30:0] x2,
			logic [30:0] y2);
		while (send_idle != 0 && $urandom_range(99) < send_idle) @(posedge clk);
		sums_due = {sums_due, point_sum(x1, y1, x2, y2)};
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, y2, x2, y1, x1};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [30:0] val);
		while (sums_due.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CURVE_A) mod_a = 64'(val);
		else mod_p = 64'(val);
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
		if (m_axis_tvalid && m_axis_tready) begin
			if (sums_due.size() == 0) begin
				$display("%0t: unexpected word %h/%b", $time, m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				sum_t e;
				e = sums_due.pop_front();
				if (m_axis_tdata[30:0] !== e.x || m_axis_tdata[61:31] !== e.y
						|| m_axis_tdata[63:62] !== 2'b0 || m_axis_tuser !== e.inf) begin
					$display("%0t: expected x=%0d y=%0d inf=%b, got x=%0d y=%0d inf=%b",
						$time, e.x, e.y, e.inf, m_axis_tdata[30:0], m_axis_tdata[61:31],
						m_axis_tuser);
					errors++;
				end
			end
		end
	end

	function automatic logic [30:0] coord(logic [63:0] p);
		// Mostly reduced values; sometimes any 31-bit value to cover reduction.
		if ($urandom_range(9) == 0) return 31'($urandom);
		return 31'($urandom % p);
	endfunction

	task automatic test_directed();
		logic [30:0] mx;
		mx = 31'h7fffffff;
		send_points(0, 0, 0, 0);
		send_points(3, 5, 3, 5);
		send_points(3, 5, 3, 6);
		send_points(2, 1, 7, 9);
		send_points(mx, mx, mx, mx);
		send_points(mx, 0, 0, mx);
		send_points(10, 10, 0, 0);
		send_points(14, 3, 3, 3);
		write_reg(REG_PRIME, 31'h7fffffff);
		write_reg(REG_CURVE_A, 31'h7ffffffe);
		send_points(mx - 31'd1, mx - 31'd1, 0, 1);
		send_points(mx - 31'd1, mx - 31'd1, mx - 31'd1, mx - 31'd1);
		send_points(12345, 0, 12345, 0);
		send_points(mx, mx, 0, 0);
		send_points(31'h2aaaaaaa, 31'h55555555, 31'h55555555, 31'h2aaaaaaa);
		write_reg(REG_PRIME, 0);
		send_points(1, 2, 3, 4);
		write_reg(REG_PRIME, 1);
		send_points(1, 2, 1, 2);
		write_reg(REG_PRIME, 3);
		write_reg(REG_CURVE_A, 0);
		send_points(1, 1, 1, 1);
		send_points(2, 0, 2, 0);
		send_points(0, 1, 2, 2);
		write_reg(REG_PRIME, 15);
		send_points(4, 7, 9, 2);
	endtask

	task automatic test_random(int n);
		logic [30:0] primes[6] = '{31'h7fffffff, 31'd3, 31'd65521, 31'd1000003, 31'd97,
			31'd2147483629};
		logic [30:0] x, y;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_PRIME, primes[ph]);
			write_reg(REG_CURVE_A, (ph == 2) ? 31'h7fffffff : 31'($urandom % primes[ph]));
			for (int i = 0; i < n / 6; i++) begin
				x = coord(mod_p);
				y = coord(mod_p);
				case ($urandom_range(5))
					0: send_points(x, y, x, y);
					1: send_points(x, y, x, coord(mod_p));
					default: send_points(x, y, coord(mod_p), coord(mod_p));
				endcase
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 7;
		recv_idle = 48;
		test_directed();
		test_random(480);
		send_idle = 48;
		recv_idle = 7;
		test_random(480);
		send_idle = 0;
		recv_idle = 0;
		test_random(480);
		while (sums_due.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

@@ filelist.f @@
hw/rtl/ecpa_pkg.sv
hw/rtl/ecpa_modmul.sv
hw/rtl/ecpa_modred.sv
hw/rtl/elliptic_curve_point_add_core.sv
tb/elliptic_curve_point_add_core_tb.sv
